FILE: hdl/prpi_pkg.sv
// Package: sizes, register map and state codes for the PageRank engine.
package prpi_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 1024;

  localparam int NODE_W   = $clog2(MAX_NODES);
  localparam int NCNT_W   = NODE_W + 1;
  localparam int EDGE_AW  = $clog2(MAX_EDGES);
  localparam int ECNT_W   = EDGE_AW + 1;
  localparam int WGT_W    = 16;
  localparam int EDGE_DW  = 2 * NODE_W + WGT_W;
  localparam int DAMP_W   = 16;
  localparam int NCFG_W   = 7;
  localparam int ITER_W   = 8;
  localparam int RANK_W   = 32;
  localparam int DEG_W    = 27;
  localparam int SUM_W    = 44;
  localparam int SUM_LO_W = 22;
  localparam int SUM_HI_W = SUM_W - SUM_LO_W;
  localparam int BASE_W   = 31;
  localparam int DIV_N_W  = WGT_W + RANK_W;
  localparam int DIV_C_W  = $clog2(DIV_N_W);
  localparam int FIX_SH   = 16;

  localparam int PADDR_W  = 5;

  typedef enum logic [2:0] {
    REG_DAMPING   = 3'd0,
    REG_DIRECTED  = 3'd1,
    REG_WEIGHTED  = 3'd2,
    REG_NODES     = 3'd3,
    REG_ITERS     = 3'd4
  } reg_idx_e;

  localparam logic [DAMP_W-1:0] DAMP_RST  = 16'd55706;
  localparam logic [NCFG_W-1:0] NODES_RST = 7'd64;
  localparam logic [ITER_W-1:0] ITERS_RST = 8'd63;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DCLR, ST_DERD, ST_DELAT, ST_DDRD, ST_DDWR,
    ST_BDIV, ST_RDIV, ST_RINIT,
    ST_SCLR, ST_IERD, ST_IELAT, ST_ISRD, ST_IPROD, ST_IDIV, ST_IARD, ST_IAWR,
    ST_URD, ST_ULO, ST_UHI, ST_UWR,
    ST_ORD, ST_OLAT, ST_OSHOW
  } state_e;

endpackage

FILE: hdl/prpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pagerank_power_iteration.sv
// PageRank power iteration engine: edge store, degree build, iterations, rank output.
//
//  channel   | dir | contents
//  s_axis    | in  | tdata {weight, target, source}, tuser mode (0 load, 1 run)
//  m_axis    | out | tdata {rank, node}, tlast on the final node
//  apb       | cfg | damping, directed, weighted, node count, iteration count
//
// A load request writes one edge unless 1024 are held. A run request clears 64 degrees,
// reads each edge and adds its weight to the degree of each side (source when directed,
// both when undirected), then runs two divisions for the base term and 1/N and seeds
// the ranks. Each iteration clears the sums, adds each edge share and updates each rank;
// the 48-step restoring divider per share sets the run time. Output holds on stalls.
// Reset is asynchronous; RAM contents are not reset and the edge count clears.
// Input is stalled for the whole run; each result holds until taken.
module pagerank_power_iteration
  import prpi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // source_node, target_node, edge_weight
  input  logic                s_axis_tuser,  // mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // node_index, rank_value
  output logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration
  logic [DAMP_W-1:0] damping_q;
  logic              directed_q, weighted_q;
  logic [NCFG_W-1:0] nodes_q;
  logic [ITER_W-1:0] iters_q;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q  <= DAMP_RST;
      directed_q <= 1'b1;
      weighted_q <= 1'b0;
      nodes_q    <= NODES_RST;
      iters_q    <= ITERS_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_DAMPING:  damping_q  <= pwdata[DAMP_W-1:0];
        REG_DIRECTED: directed_q <= pwdata[0];
        REG_WEIGHTED: weighted_q <= pwdata[0];
        REG_NODES:    nodes_q    <= pwdata[NCFG_W-1:0];
        REG_ITERS:    iters_q    <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DAMPING:  prdata = 32'(damping_q);
      REG_DIRECTED: prdata = 32'(directed_q);
      REG_WEIGHTED: prdata = 32'(weighted_q);
      REG_NODES:    prdata = 32'(nodes_q);
      REG_ITERS:    prdata = 32'(iters_q);
      default:      prdata = '0;
    endcase
  end

  // effective node count
  logic [NCNT_W-1:0] n_eff, n_last;
  always_comb begin
    if (nodes_q == '0) n_eff = NCNT_W'(1);
    else if (NCNT_W'(nodes_q) > NCNT_W'(MAX_NODES)) n_eff = NCNT_W'(MAX_NODES);
    else n_eff = NCNT_W'(nodes_q);
  end
  assign n_last = n_eff - NCNT_W'(1);

  // memories
  logic                 edge_we, deg_we, rank_we, sum_we;
  logic [EDGE_AW-1:0]   edge_raddr;
  logic [EDGE_DW-1:0]   edge_rdata;
  logic [NODE_W-1:0]    deg_waddr, deg_raddr, rank_waddr, rank_raddr;
  logic [NODE_W-1:0]    sum_waddr, sum_raddr;
  logic [DEG_W-1:0]     deg_wdata, deg_rdata;
  logic [RANK_W-1:0]    rank_wdata, rank_rdata;
  logic [SUM_W-1:0]     sum_wdata, sum_rdata;
  logic [ECNT_W-1:0]    cnt_q, cnt_d;

  prpi_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(cnt_q[EDGE_AW-1:0]),
    .wdata_i(s_axis_tdata[EDGE_DW-1:0]), .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  prpi_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );
  prpi_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank_ram (
    .clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_wdata),
    .raddr_i(rank_raddr), .rdata_o(rank_rdata)
  );
  prpi_ram #(.WIDTH(SUM_W), .DEPTH(MAX_NODES)) u_sum_ram (
    .clk_i, .we_i(sum_we), .waddr_i(sum_waddr), .wdata_i(sum_wdata),
    .raddr_i(sum_raddr), .rdata_o(sum_rdata)
  );

  // sequencer registers
  state_e              state_q, state_d;
  logic [NCNT_W-1:0]   i_q, i_d;
  logic [ECNT_W-1:0]   e_q, e_d;
  logic [ITER_W-1:0]   k_q, k_d;
  logic                side_q, side_d;
  logic [NODE_W-1:0]   src_q, src_d, dst_q, dst_d;
  logic [WGT_W-1:0]    w_q, w_d;
  logic [DIV_N_W-1:0]  num_q, num_d;
  logic [DEG_W-1:0]    rem_q, rem_d, den_q, den_d;
  logic [DIV_C_W-1:0]  dcnt_q, dcnt_d;
  logic [BASE_W-1:0]   base_q, base_d, init_q, init_d;
  logic [RANK_W-1:0]   share_q, share_d;
  logic [SUM_HI_W-1:0] shi_q, shi_d;
  logic [DAMP_W+SUM_LO_W-1:0] plo_q, plo_d;
  logic [DAMP_W+SUM_HI_W-1:0] phi_q, phi_d;
  logic [NODE_W-1:0]   onode_q, onode_d;
  logic [RANK_W-1:0]   orank_q, orank_d;
  logic                olast_q, olast_d;

  // restoring divider step
  logic [DEG_W:0]      rem_sh;
  logic [DEG_W+1:0]    rem_diff;
  logic                q_bit, div_last;
  logic [DIV_N_W-1:0]  num_step;
  logic [DEG_W-1:0]    rem_step;

  assign rem_sh   = {rem_q, num_q[DIV_N_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, den_q};
  assign q_bit    = !rem_diff[DEG_W+1];
  assign rem_step = q_bit ? rem_diff[DEG_W-1:0] : rem_sh[DEG_W-1:0];
  assign num_step = {num_q[DIV_N_W-2:0], q_bit};
  assign div_last = (dcnt_q == DIV_C_W'(DIV_N_W - 1));

  // edge fields and update arithmetic
  logic [NODE_W-1:0] e_src, e_tgt;
  logic [WGT_W-1:0]  e_wgt;
  logic              e_ok;
  logic [DAMP_W+SUM_W-1:0] dsum;
  logic [SUM_W:0]          upd;
  logic [16:0]             damp_comp;

  assign e_src = edge_rdata[NODE_W-1:0];
  assign e_tgt = edge_rdata[2*NODE_W-1:NODE_W];
  assign e_wgt = edge_rdata[EDGE_DW-1:2*NODE_W];
  assign e_ok  = (NCNT_W'(e_src) < n_eff) && (NCNT_W'(e_tgt) < n_eff);
  assign dsum  = {phi_q, {SUM_LO_W{1'b0}}} + (DAMP_W+SUM_W)'(plo_q);
  assign upd   = (SUM_W+1)'(dsum[DAMP_W+SUM_W-1:FIX_SH]) + (SUM_W+1)'(base_q);
  assign damp_comp = 17'h10000 - {1'b0, damping_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OSHOW);
  assign m_axis_tdata  = {2'b00, orank_q, onode_q};
  assign m_axis_tlast  = olast_q;

  always_comb begin
    state_d = state_q;  i_d = i_q;  e_d = e_q;  k_d = k_q;  cnt_d = cnt_q;
    side_d = side_q;  src_d = src_q;  dst_d = dst_q;  w_d = w_q;
    num_d = num_q;  rem_d = rem_q;  den_d = den_q;  dcnt_d = dcnt_q;
    base_d = base_q;  init_d = init_q;  share_d = share_q;
    shi_d = shi_q;  plo_d = plo_q;  phi_d = phi_q;
    onode_d = onode_q;  orank_d = orank_q;  olast_d = olast_q;
    edge_we = 1'b0;  edge_raddr = e_q[EDGE_AW-1:0];
    deg_we = 1'b0;  deg_waddr = src_q;  deg_raddr = src_q;  deg_wdata = '0;
    rank_we = 1'b0;  rank_waddr = i_q[NODE_W-1:0];  rank_raddr = src_q;
    rank_wdata = RANK_W'(init_q);
    sum_we = 1'b0;  sum_waddr = i_q[NODE_W-1:0];  sum_raddr = dst_q;  sum_wdata = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            if (cnt_q < ECNT_W'(MAX_EDGES)) begin
              edge_we = 1'b1;
              cnt_d   = cnt_q + ECNT_W'(1);
            end
          end else begin
            i_d     = '0;
            state_d = ST_DCLR;
          end
        end
      end

      // degree build
      ST_DCLR: begin
        deg_we    = 1'b1;
        deg_waddr = i_q[NODE_W-1:0];
        i_d       = i_q + NCNT_W'(1);
        if (i_q == NCNT_W'(MAX_NODES - 1)) begin
          e_d = '0;
          if (cnt_q == '0) begin
            num_d = DIV_N_W'({damp_comp, 14'b0});
            den_d = DEG_W'(n_eff);  rem_d = '0;  dcnt_d = '0;
            state_d = ST_BDIV;
          end else begin
            state_d = ST_DERD;
          end
        end
      end
      ST_DERD: state_d = ST_DELAT;
      ST_DELAT: begin
        src_d  = e_src;
        dst_d  = e_tgt;
        w_d    = weighted_q ? e_wgt : WGT_W'(1);
        side_d = 1'b0;
        if (e_ok) begin
          state_d = ST_DDRD;
        end else if (e_q + ECNT_W'(1) == cnt_q) begin
          num_d = DIV_N_W'({damp_comp, 14'b0});
          den_d = DEG_W'(n_eff);  rem_d = '0;  dcnt_d = '0;
          state_d = ST_BDIV;
        end else begin
          e_d = e_q + ECNT_W'(1);
          state_d = ST_DERD;
        end
      end
      ST_DDRD: begin
        deg_raddr = side_q ? dst_q : src_q;
        state_d   = ST_DDWR;
      end
      ST_DDWR: begin
        deg_we    = 1'b1;
        deg_waddr = side_q ? dst_q : src_q;
        deg_wdata = deg_rdata + DEG_W'(w_q);
        if (!directed_q && !side_q) begin
          side_d  = 1'b1;
          state_d = ST_DDRD;
        end else if (e_q + ECNT_W'(1) == cnt_q) begin
          num_d = DIV_N_W'({damp_comp, 14'b0});
          den_d = DEG_W'(n_eff);  rem_d = '0;  dcnt_d = '0;
          state_d = ST_BDIV;
        end else begin
          e_d = e_q + ECNT_W'(1);
          state_d = ST_DERD;
        end
      end

      // base term and initial rank
      ST_BDIV: begin
        num_d = num_step;  rem_d = rem_step;  dcnt_d = dcnt_q + DIV_C_W'(1);
        if (div_last) begin
          base_d = num_step[BASE_W-1:0];
          num_d  = DIV_N_W'(1) << 30;
          rem_d  = '0;  dcnt_d = '0;
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        num_d = num_step;  rem_d = rem_step;  dcnt_d = dcnt_q + DIV_C_W'(1);
        if (div_last) begin
          init_d  = num_step[BASE_W-1:0];
          i_d     = '0;
          state_d = ST_RINIT;
        end
      end
      ST_RINIT: begin
        rank_we = 1'b1;
        i_d     = i_q + NCNT_W'(1);
        if (i_q == n_last) begin
          k_d = iters_q;
          i_d = '0;
          state_d = (iters_q == '0) ? ST_ORD : ST_SCLR;
        end
      end

      // one iteration: clear sums, accumulate shares
      ST_SCLR: begin
        sum_we = 1'b1;
        i_d    = i_q + NCNT_W'(1);
        if (i_q == n_last) begin
          e_d = '0;
          i_d = '0;
          state_d = (cnt_q == '0) ? ST_URD : ST_IERD;
        end
      end
      ST_IERD: state_d = ST_IELAT;
      ST_IELAT: begin
        src_d  = e_src;
        dst_d  = e_tgt;
        w_d    = weighted_q ? e_wgt : WGT_W'(1);
        side_d = 1'b0;
        if (e_ok) begin
          state_d = ST_ISRD;
        end else if (e_q + ECNT_W'(1) == cnt_q) begin
          i_d = '0;  state_d = ST_URD;
        end else begin
          e_d = e_q + ECNT_W'(1);  state_d = ST_IERD;
        end
      end
      ST_ISRD: begin
        deg_raddr  = side_q ? dst_q : src_q;
        rank_raddr = side_q ? dst_q : src_q;
        state_d    = ST_IPROD;
      end
      ST_IPROD: begin
        if (deg_rdata == '0) begin
          // skip a neighbor with no degree
          if (!directed_q && !side_q) begin
            side_d = 1'b1;  state_d = ST_ISRD;
          end else if (e_q + ECNT_W'(1) == cnt_q) begin
            i_d = '0;  state_d = ST_URD;
          end else begin
            e_d = e_q + ECNT_W'(1);  state_d = ST_IERD;
          end
        end else begin
          num_d = w_q * rank_rdata;
          den_d = deg_rdata;  rem_d = '0;  dcnt_d = '0;
          state_d = ST_IDIV;
        end
      end
      ST_IDIV: begin
        num_d = num_step;  rem_d = rem_step;  dcnt_d = dcnt_q + DIV_C_W'(1);
        if (div_last) begin
          share_d = num_step[RANK_W-1:0];
          state_d = ST_IARD;
        end
      end
      ST_IARD: begin
        sum_raddr = side_q ? src_q : dst_q;
        state_d   = ST_IAWR;
      end
      ST_IAWR: begin
        sum_we    = 1'b1;
        sum_waddr = side_q ? src_q : dst_q;
        sum_wdata = sum_rdata + SUM_W'(share_q);
        if (!directed_q && !side_q) begin
          side_d = 1'b1;  state_d = ST_ISRD;
        end else if (e_q + ECNT_W'(1) == cnt_q) begin
          i_d = '0;  state_d = ST_URD;
        end else begin
          e_d = e_q + ECNT_W'(1);  state_d = ST_IERD;
        end
      end

      // rank update: base + (d * sum) >> 16, in two partial products
      ST_URD: begin
        sum_raddr = i_q[NODE_W-1:0];
        state_d   = ST_ULO;
      end
      ST_ULO: begin
        plo_d   = damping_q * sum_rdata[SUM_LO_W-1:0];
        shi_d   = sum_rdata[SUM_W-1:SUM_LO_W];
        state_d = ST_UHI;
      end
      ST_UHI: begin
        phi_d   = damping_q * shi_q;
        state_d = ST_UWR;
      end
      ST_UWR: begin
        rank_we    = 1'b1;
        rank_wdata = (upd > (SUM_W+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : upd[RANK_W-1:0];
        i_d        = i_q + NCNT_W'(1);
        state_d    = ST_URD;
        if (i_q == n_last) begin
          k_d = k_q - ITER_W'(1);
          i_d = '0;
          state_d = (k_q == ITER_W'(1)) ? ST_ORD : ST_SCLR;
        end
      end

      // output
      ST_ORD: begin
        rank_raddr = i_q[NODE_W-1:0];
        state_d    = ST_OLAT;
      end
      ST_OLAT: begin
        orank_d = rank_rdata;
        onode_d = i_q[NODE_W-1:0];
        olast_d = (i_q == n_last);
        state_d = ST_OSHOW;
      end
      ST_OSHOW: begin
        if (m_axis_tready) begin
          if (olast_q) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + NCNT_W'(1);
            state_d = ST_ORD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      e_q     <= '0;
      k_q     <= '0;
      side_q  <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      e_q     <= e_d;
      k_q     <= k_d;
      side_q  <= side_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    dst_q   <= dst_d;
    w_q     <= w_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    base_q  <= base_d;
    init_q  <= init_d;
    share_q <= share_d;
    shi_q   <= shi_d;
    plo_q   <= plo_d;
    phi_q   <= phi_d;
    onode_q <= onode_d;
    orank_q <= orank_d;
    olast_q <= olast_d;
  end

endmodule
